[design/mtsp_pkg.sv]
// Package for the max threshold shortest path unit: ops, states, constants.
// No dependencies.
`default_nettype none
package mtsp_pkg;
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_INIT,
        S_SCAN,
        S_SCAN_END,
        S_RELAX,
        S_RELAX_WR,
        S_RD_LAST,
        S_DECIDE,
        S_OUT
    } t_state;

    localparam logic [29:0] DIST_INF = 30'd1000000000;

    localparam logic [2:0] REG_NODE_COUNT = 3'd0;
    localparam logic [2:0] REG_SEARCH_LOW = 3'd1;
    localparam logic [2:0] REG_SEARCH_HIGH = 3'd2;
    localparam logic [2:0] REG_SCALE = 3'd3;
    localparam logic [2:0] REG_OFFSET = 3'd4;
    localparam logic [2:0] REG_BUDGET = 3'd5;
endpackage
`default_nettype wire

[design/max_threshold_shortest_path_unit.sv]
// Top level of the max threshold shortest path unit: edge store, search control, Dijkstra.
// Depends on mtsp_pkg and mtsp_ram.
`default_nettype none
// Edge loads and clears are accepted back to back while idle. A start
// beat runs a binary search. Each probe picks the midpoint in S_CHECK and forms
// the capacity threshold in S_MUL. It then sweeps the node memory to set distances
// to infinity (node 1 to zero). For every node it settles, it runs a scan of nodes
// 1..L, where L is the clamped node count (one node memory read per cycle).
// It follows the scan with a relax pass over all stored edges (per edge, an edge
// memory read in S_RELAX, then a read-modify-write of the far end's distance in
// S_RELAX_WR, plus a closing S_RELAX step). A last scan that finds no node, a read
// of the target's distance and the decision close the probe. The search runs about
// log2(search_high - search_low) probes. The result beat sits in an output register
// and the input side stays stalled until it is taken.
module max_threshold_shortest_path_unit
    import mtsp_pkg::*;
#(
    parameter int MAX_NODES = 256,
    parameter int MAX_EDGES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: end_a[7:0], end_b[15:8], edge_length[35:16], edge_capacity[65:36],
    // zero pad to 72 bits
    input  wire logic [71:0] s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: answer[23:0]
    output logic      [23:0] m_axis_tdata,
    // tuser: edge_overflow[0]
    output logic             m_axis_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int NW = $clog2(MAX_NODES);
    localparam int TW = EW + 1;
    localparam logic [7:0] LAST_MAX = 8'(MAX_NODES - 1);

    // Configuration registers.
    logic [7:0]  r_node_count;
    logic [23:0] r_search_low, r_search_high;
    logic [9:0]  r_scale;
    logic [25:0] r_offset;
    logic [29:0] r_budget;
    logic [2:0]  w_reg;

    assign pready = 1'b1;
    assign w_reg = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count  <= 8'd1;
            r_search_low  <= 24'd0;
            r_search_high <= 24'd10000001;
            r_scale       <= 10'd100;
            r_offset      <= 26'd3000000;
            r_budget      <= 30'd1440;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            unique case (w_reg)
                REG_NODE_COUNT:  r_node_count  <= pwdata[7:0];
                REG_SEARCH_LOW:  r_search_low  <= pwdata[23:0];
                REG_SEARCH_HIGH: r_search_high <= pwdata[23:0];
                REG_SCALE:       r_scale       <= pwdata[9:0];
                REG_OFFSET:      r_offset      <= pwdata[25:0];
                REG_BUDGET:      r_budget      <= pwdata[29:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00) begin
            unique case (w_reg)
                REG_NODE_COUNT:  prdata = {24'd0, r_node_count};
                REG_SEARCH_LOW:  prdata = {8'd0, r_search_low};
                REG_SEARCH_HIGH: prdata = {8'd0, r_search_high};
                REG_SCALE:       prdata = {22'd0, r_scale};
                REG_OFFSET:      prdata = {6'd0, r_offset};
                REG_BUDGET:      prdata = {2'd0, r_budget};
                default:         prdata = 32'd0;
            endcase
        end
    end

    // Input fields.
    t_op         in_op;
    logic [7:0]  in_a, in_b;
    logic [19:0] in_len;
    logic [29:0] in_cap;
    assign in_op  = t_op'(s_axis_tuser);
    assign in_a   = s_axis_tdata[7:0];
    assign in_b   = s_axis_tdata[15:8];
    assign in_len = s_axis_tdata[35:16];
    assign in_cap = s_axis_tdata[65:36];

    t_state r_state, n_state;
    logic in_acc;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Edge store: total count and overflow flag.
    logic [TW-1:0] r_total;
    logic          r_ovf;
    logic          edge_we;
    assign edge_we = in_acc && in_op == OP_LOAD && r_total < TW'(MAX_EDGES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_ovf   <= 1'b0;
        end else if (in_acc && in_op == OP_CLEAR) begin
            r_total <= '0;
            r_ovf   <= 1'b0;
        end else if (in_acc && in_op == OP_LOAD) begin
            if (edge_we) r_total <= r_total + 1'b1;
            else r_ovf <= 1'b1;
        end
    end

    // Search registers.
    logic [23:0] r_lo, r_hi, r_mid;
    logic [7:0]  r_last;
    logic [34:0] r_prod;
    logic [35:0] r_limit;
    logic [NW-1:0] r_idx;      // node sweep / scan index
    logic [TW-1:0] r_eidx;     // edge index
    logic [7:0]  r_v;          // selected node (0 = none)
    logic [29:0] r_best, r_vdist;
    logic        r_scan_rd;    // a node read is in flight during scan
    logic [7:0]  r_scan_node;
    logic [23:0] r_answer;
    logic        r_out_ovf;

    // Node memory: {settled, distance}.
    logic          nd_we;
    logic [NW-1:0] nd_waddr, nd_raddr;
    logic [30:0]   nd_wdata, nd_rdata;
    mtsp_ram #(.WIDTH(31), .DEPTH(MAX_NODES)) u_node_ram (
        .i_clk(i_clk), .i_we(nd_we), .i_waddr(nd_waddr), .i_wdata(nd_wdata),
        .i_raddr(nd_raddr), .o_rdata(nd_rdata)
    );

    // Edge memory: {capacity, length, b, a}.
    logic [EW-1:0] ed_raddr;
    logic [65:0]   ed_rdata;
    mtsp_ram #(.WIDTH(66), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(r_total[EW-1:0]),
        .i_wdata({in_cap, in_len, in_b, in_a}), .i_raddr(ed_raddr), .o_rdata(ed_rdata)
    );

    logic [7:0]  e_a, e_b, e_to;
    logic [19:0] e_len;
    logic [29:0] e_cap;
    logic        e_use;
    logic [30:0] sum;
    logic [29:0] nd_new;
    assign e_a   = ed_rdata[7:0];
    assign e_b   = ed_rdata[15:8];
    assign e_len = ed_rdata[35:16];
    assign e_cap = ed_rdata[65:36];
    assign e_to  = (e_a == r_v) ? e_b : e_a;
    assign e_use = e_a != 8'd0 && e_b != 8'd0 && e_a <= r_last && e_b <= r_last
                   && {6'd0, e_cap} >= r_limit && (e_a == r_v || e_b == r_v);
    assign sum    = {1'b0, r_vdist} + {11'd0, e_len};
    assign nd_new = (sum >= {1'b0, DIST_INF}) ? DIST_INF : sum[29:0];

    // Relax write happens in the cycle after the edge read; hold the target.
    logic [7:0]  r_to;
    logic [29:0] r_nd;
    logic        r_upd;

    logic [24:0] mid_sum;
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};

    logic scan_done;
    assign scan_done = (r_idx == NW'(r_last)) || (r_idx == NW'(MAX_NODES - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (in_acc && in_op == OP_START) n_state = S_CHECK;
            S_CHECK:    n_state = ({1'b0, r_lo} + 25'd1 < {1'b0, r_hi}) ? S_MUL : S_OUT;
            S_MUL:      n_state = S_INIT;
            S_INIT:     if (r_idx == NW'(MAX_NODES - 1)) n_state = S_SCAN;
            S_SCAN:     if (scan_done) n_state = S_SCAN_END;
            S_SCAN_END: n_state = (r_v == 8'd0 && !(r_scan_rd && !nd_rdata[30]
                                   && nd_rdata[29:0] < r_best)) ? S_RD_LAST : S_RELAX;
            S_RELAX:    n_state = (r_eidx >= r_total) ? S_SCAN : S_RELAX_WR;
            S_RELAX_WR: n_state = S_RELAX;
            S_RD_LAST:  n_state = S_DECIDE;
            S_DECIDE:   n_state = S_CHECK;
            S_OUT:      if (m_axis_tready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Memory addressing and writes.
    always_comb begin
        nd_we    = 1'b0;
        nd_waddr = r_idx;
        nd_wdata = {1'b0, DIST_INF};
        nd_raddr = r_idx;
        ed_raddr = r_eidx[EW-1:0];
        unique case (r_state)
            S_INIT: begin
                nd_we    = 1'b1;
                nd_wdata = {1'b0, (r_idx == NW'(1)) ? 30'd0 : DIST_INF};
            end
            S_SCAN_END: begin
                nd_raddr = NW'(r_scan_node);
            end
            S_RELAX: begin
                nd_raddr = NW'(e_to);
                if (r_eidx == '0) begin
                    // Mark the selected node settled.
                    nd_we    = 1'b1;
                    nd_waddr = NW'(r_v);
                    nd_wdata = {1'b1, r_vdist};
                end
            end
            S_RELAX_WR: begin
                nd_raddr = NW'(r_to);
                nd_waddr = NW'(r_to);
                nd_wdata = {nd_rdata[30], r_nd};
                nd_we    = r_upd && r_nd < nd_rdata[29:0];
            end
            S_RD_LAST: nd_raddr = NW'(r_last);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_lo   <= r_search_low;
                r_hi   <= r_search_high;
                r_last <= (r_node_count == 8'd0) ? 8'd1 :
                          (r_node_count > LAST_MAX) ? LAST_MAX : r_node_count;
            end
            S_CHECK: begin
                r_mid  <= mid_sum[24:1];
                r_prod <= 35'(mid_sum[24:1]) * 35'(r_scale);
                r_idx  <= '0;
            end
            S_MUL: r_limit <= {1'b0, r_prod} + {10'd0, r_offset};
            S_INIT: begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == NW'(MAX_NODES - 1)) begin
                    r_idx       <= NW'(1);
                    r_v         <= 8'd0;
                    r_best      <= DIST_INF;
                    r_scan_rd   <= 1'b0;
                end
            end
            S_SCAN: begin
                // Compare the node read last cycle, issue the next read.
                if (r_scan_rd && !nd_rdata[30] && nd_rdata[29:0] < r_best) begin
                    r_best <= nd_rdata[29:0];
                    r_v    <= r_scan_node;
                end
                r_scan_rd   <= 1'b1;
                r_scan_node <= 8'(r_idx);
                if (!scan_done) r_idx <= r_idx + 1'b1;
                r_eidx <= '0;
            end
            S_SCAN_END: begin
                if (r_scan_rd && !nd_rdata[30] && nd_rdata[29:0] < r_best) begin
                    r_best  <= nd_rdata[29:0];
                    r_v     <= r_scan_node;
                    r_vdist <= nd_rdata[29:0];
                end else begin
                    r_vdist <= r_best;
                end
                r_eidx <= '0;
            end
            S_RELAX: begin
                r_to   <= e_to;
                r_nd   <= nd_new;
                r_upd  <= e_use && r_eidx < r_total;
                r_eidx <= r_eidx + 1'b1;
                if (r_eidx >= r_total) begin
                    r_idx     <= NW'(1);
                    r_v       <= 8'd0;
                    r_best    <= DIST_INF;
                    r_scan_rd <= 1'b0;
                end
            end
            S_DECIDE: begin
                if (nd_rdata[29:0] <= r_budget) r_lo <= r_mid;
                else r_hi <= r_mid;
            end
            default: ;
        endcase
        if (r_state == S_CHECK && n_state == S_OUT) begin
            r_answer  <= r_lo;
            r_out_ovf <= r_ovf;
        end
    end

    // Edge reads in S_RELAX: the address r_eidx is presented from S_SCAN_END / S_RELAX_WR,
    // so the data seen in S_RELAX belongs to r_eidx - the registered read gives it in the
    // cycle after presentation; ed_raddr always follows r_eidx, which is stable in
    // S_RELAX_WR and S_SCAN_END.

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_answer;
    assign m_axis_tuser  = r_out_ovf;

    // Assertions.
    a_no_in_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(MAX_EDGES))
        else $error("edge count past capacity");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat dropped");
endmodule
`default_nettype wire

[design/mtsp_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
// Uses no package.
`default_nettype none
module mtsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
